// File: src/trle_pkg.sv
// Shared types, constants and helpers for the threshold run-length encoder.
package trle_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned MaxRes  = 5;
  localparam int unsigned CntW    = $clog2(MaxRes + 1);

  localparam logic [PixW-1:0] ThresholdRst = 8'd128;
  localparam logic [LenW-1:0] ByteLimitRst = 16'd1024;
  localparam logic [LenW-1:0] RunMax       = 16'hFFFF;

  typedef enum logic [KindW-1:0] {
    KIND_DATA     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD  = 1'b0,
    CFG_BYTE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  coded_length;
    logic             last_of_run;
  } res_t;

  // All results caused by one pixel, slot 0 first.
  typedef struct packed {
    res_t [MaxRes-1:0] slot;
    logic [CntW-1:0]   n;
  } pkt_t;

  typedef struct packed {
    logic room;   // a new packet may load this cycle
    logic empty;  // no results waiting in the queue
  } q_status_t;

  function automatic logic [LenW-1:0] sat_add2(input logic [LenW-1:0] v);
    logic [LenW:0] sum;
    sum = {1'b0, v} + (LenW+1)'(2);
    return sum[LenW] ? RunMax : sum[LenW-1:0];
  endfunction

  function automatic res_t mk_res(input kind_e k, input logic [ByteW-1:0] b,
                                  input logic [LenW-1:0] len);
    res_t r;
    r.kind         = k;
    r.data_byte    = b;
    r.coded_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// File: src/trle_resq.sv
// Result queue: holds one pixel's results and feeds them to the output register.
module trle_resq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  trle_pkg::pkt_t      pkt_i,
  output trle_pkg::q_status_t st_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trle_pkg::res_t      out_o
);
  import trle_pkg::*;

  res_t [MaxRes-1:0] slot_q;
  logic [CntW-1:0]   cnt_q;
  logic              ov_q;
  res_t              out_q;
  logic              move;

  // advance when a result waits and the output register is free or draining
  assign move        = (cnt_q != '0) && (!ov_q || !out_stall_i);
  assign st_o.room   = (cnt_q == '0) || ((cnt_q == CntW'(1)) && move);
  assign st_o.empty  = (cnt_q == '0);
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load_i) begin
        cnt_q <= pkt_i.n;
      end else if (move) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (move) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= pkt_i.slot;
    end else if (move) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
    if (move) begin
      out_q <= slot_q[0];
    end
  end

endmodule

// File: src/threshold_run_length_encoder_top.sv
// Top level of the threshold run-length encoder.
// Usage:
//   Input channel: pixel_i and frame_end_i with in_valid_i; the block drives
//   in_stall_o. A transfer happens on a clock edge with valid high, stall low.
//   Output channel: kind_o, data_byte_o, coded_length_o, last_of_run_o with
//   out_valid_o; the receiver drives out_stall_i.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 threshold, 1 byte
//   limit) and cfg_data_i; write only while the block is idle.
//   A pixel's results are computed at its transfer and held in a small queue;
//   each result then moves from the queue to the output register and
//   transfers from there, one result per cycle while out_stall_i is low.
//   A pixel gives no result while its run goes on, two on a color change,
//   and up to five at a frame end. A new pixel is taken in the cycle the
//   last queued result moves to the output register.
//   Reset clears the run state, the queue and the output valid and loads
//   threshold 128 and byte limit 1024. A stalled output holds its result;
//   the queue then fills and in_stall_o rises.
module threshold_run_length_encoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [trle_pkg::PixW-1:0]     pixel_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [trle_pkg::KindW-1:0]    kind_o,
  output logic [trle_pkg::ByteW-1:0]    data_byte_o,
  output logic [trle_pkg::LenW-1:0]     coded_length_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trle_pkg::CfgW-1:0]     cfg_data_i
);
  import trle_pkg::*;

  logic [PixW-1:0] thr_q;
  logic [LenW-1:0] limit_q;
  logic [LenW-1:0] run_q, run_d;
  logic            prev_q, prev_d;
  logic [LenW-1:0] total_q, total_d;
  logic            halted_q, halted_d;

  logic            in_acc;
  logic            white, cont, ovf, prev1;
  logic [LenW-1:0] run1, tot1, tot2;
  res_t [2:0]      tail;
  logic [CntW-1:0] tn;
  pkt_t            pkt;
  q_status_t       q_st;
  res_t            out_res;
  cfg_reg_e        cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !q_st.room;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_idx     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThresholdRst;
      limit_q <= ByteLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx)
        CFG_THRESHOLD:  thr_q   <= cfg_data_i[PixW-1:0];
        CFG_BYTE_LIMIT: limit_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    white = pixel_i > thr_q;
    cont  = (white == prev_q) && (run_q != RunMax);
    tot1  = cont ? total_q : sat_add2(total_q);
    run1  = cont ? run_q + LenW'(1) : LenW'(1);
    prev1 = cont ? prev_q : white;
    ovf   = tot1 >= limit_q;
    tot2  = sat_add2(tot1);

    tail = '0;
    tn   = '0;
    if (ovf) begin
      tail[0] = mk_res(KIND_OVERFLOW, '0, tot1);
      tn      = CntW'(1);
    end else if (frame_end_i) begin
      tail[0] = mk_res(KIND_DATA, run1[LenW-1:ByteW], '0);
      tail[1] = mk_res(KIND_DATA, run1[ByteW-1:0], '0);
      tail[2] = mk_res(KIND_DONE, '0, tot2);
      tn      = CntW'(3);
    end

    pkt = '0;
    if (!cont) begin
      pkt.slot[0] = mk_res(KIND_DATA, run_q[LenW-1:ByteW], '0);
      pkt.slot[1] = mk_res(KIND_DATA, run_q[ByteW-1:0], '0);
      pkt.slot[2] = tail[0];
      pkt.slot[3] = tail[1];
      pkt.slot[4] = tail[2];
      pkt.n       = tn + CntW'(2);
    end else begin
      pkt.slot[0] = tail[0];
      pkt.slot[1] = tail[1];
      pkt.slot[2] = tail[2];
      pkt.n       = tn;
    end
    // a halted frame drops its pixels
    if (halted_q) begin
      pkt.n = '0;
    end
    for (int i = 0; i < MaxRes; i++) begin
      pkt.slot[i].last_of_run = (CntW'(i + 1) == pkt.n);
    end

    run_d    = run_q;
    prev_d   = prev_q;
    total_d  = total_q;
    halted_d = halted_q;
    if (in_acc) begin
      if (frame_end_i) begin
        run_d    = '0;
        prev_d   = 1'b1;
        total_d  = '0;
        halted_d = 1'b0;
      end else if (!halted_q) begin
        run_d    = run1;
        prev_d   = prev1;
        total_d  = tot1;
        halted_d = ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= '0;
      prev_q   <= 1'b1;
      total_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      run_q    <= run_d;
      prev_q   <= prev_d;
      total_q  <= total_d;
      halted_q <= halted_d;
    end
  end

  trle_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc),
    .pkt_i       (pkt),
    .st_o        (q_st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign data_byte_o    = out_res.data_byte;
  assign coded_length_o = out_res.coded_length;
  assign last_of_run_o  = out_res.last_of_run;

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && halted_q) |-> (pkt.n == '0))
    else $error("halted frame produced results");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_end_i) |=> (run_q == '0 && total_q == '0 && !halted_q && prev_q))
    else $error("frame state not cleared after frame end");

  a_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !frame_end_i) |=> (total_q >= $past(total_q)))
    else $error("coded byte total decreased inside a frame");

  a_results_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pkt.n != '0) |=> !q_st.empty)
    else $error("results lost at queue load");

endmodule

// File: tb/sv/threshold_run_length_encoder_checker.sv
// Checker for the threshold run-length encoder: predicts coded results and compares them.
`timescale 1ns / 100ps

module threshold_run_length_encoder_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [trle_pkg::PixW-1:0]      pixel_i,
  input  logic                           frame_end_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [trle_pkg::KindW-1:0]     kind_i,
  input  logic [trle_pkg::ByteW-1:0]     data_byte_i,
  input  logic [trle_pkg::LenW-1:0]      coded_length_i,
  input  logic                           last_of_run_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [trle_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trle_pkg::CfgW-1:0]      cfg_data_i,
  output int                             failures_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             overflows_o
);
  import trle_pkg::*;

  logic [PixW-1:0] thr;
  logic [LenW-1:0] limit;
  logic [LenW-1:0] run_len;
  logic [LenW-1:0] bytes_sent;
  logic            run_white;
  logic            aborted;
  res_t            coded_q[$];
  res_t            want;

  task automatic restart_frame();
    run_len    = '0;
    run_white  = 1'b1;
    bytes_sent = '0;
    aborted    = 1'b0;
  endtask

  task automatic add_code(input kind_e k, input logic [ByteW-1:0] b,
                          input logic [LenW-1:0] len);
    res_t r;
    r.kind         = k;
    r.data_byte    = b;
    r.coded_length = len;
    r.last_of_run  = 1'b0;
    coded_q.push_back(r);
  endtask

  // Send the run count high byte first; the byte total saturates.
  task automatic emit_count();
    logic [LenW:0] sum;
    add_code(KIND_DATA, run_len[LenW-1:ByteW], '0);
    add_code(KIND_DATA, run_len[ByteW-1:0], '0);
    sum = {1'b0, bytes_sent} + (LenW+1)'(2);
    bytes_sent = sum[LenW] ? '1 : sum[LenW-1:0];
  endtask

  task automatic encode_pixel(input logic [PixW-1:0] pix, input logic fe);
    logic white;
    int   first;
    first = coded_q.size();
    if (aborted) begin
      if (fe) restart_frame();
      return;
    end
    white = pix > thr;
    if (white == run_white && run_len != '1) begin
      run_len = run_len + LenW'(1);
    end else begin
      emit_count();
      run_len   = LenW'(1);
      run_white = white;
    end
    if (bytes_sent >= limit) begin
      add_code(KIND_OVERFLOW, '0, bytes_sent);
      aborted = 1'b1;
      if (fe) restart_frame();
    end else if (fe) begin
      emit_count();
      add_code(KIND_DONE, '0, bytes_sent);
      restart_frame();
    end
    // flag the last result of this pixel
    if (coded_q.size() > first) coded_q[$].last_of_run = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr   = ThresholdRst;
      limit = ByteLimitRst;
      restart_frame();
      coded_q.delete();
      failures_o  = 0;
      pending_o   = 0;
      checked_o   = 0;
      overflows_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (coded_q.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %0d coded_length %0d last_of_run %0d",
                 kind_i, data_byte_i, coded_length_i, last_of_run_i);
          failures_o++;
        end else begin
          want = coded_q.pop_front();
          if (want.kind == KIND_OVERFLOW) overflows_o++;
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_i);
            failures_o++;
          end
          if (data_byte_i !== want.data_byte) begin
            $error("data_byte: expected %0d, actual %0d", want.data_byte, data_byte_i);
            failures_o++;
          end
          if (coded_length_i !== want.coded_length) begin
            $error("coded_length: expected %0d, actual %0d", want.coded_length,
                   coded_length_i);
            failures_o++;
          end
          if (last_of_run_i !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run, last_of_run_i);
            failures_o++;
          end
        end
      end
      // a pixel taken on a write edge still sees the old settings
      if (in_valid_i && !in_stall_i) encode_pixel(pixel_i, frame_end_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_THRESHOLD: begin
            thr = cfg_data_i[PixW-1:0];
          end
          CFG_BYTE_LIMIT: begin
            limit = cfg_data_i[LenW-1:0];
          end
          default: begin
          end
        endcase
      end
      pending_o = coded_q.size();
    end
  end

endmodule

// File: tb/sv/threshold_run_length_encoder_top_test.sv
// Testbench top for the threshold run-length encoder: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module threshold_run_length_encoder_top_test;
  import trle_pkg::*;

  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhasePixels  = 45;
  localparam int unsigned NumPhases    = 7;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_i        = '0;
  logic                frame_end_i    = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [KindW-1:0]    kind_o;
  logic [ByteW-1:0]    data_byte_o;
  logic [LenW-1:0]     coded_length_o;
  logic                last_of_run_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgW-1:0]     cfg_data_i     = '0;

  int          failures;
  int          pending;
  int          checked;
  int          overflows;
  int          cycles        = 0;
  int          pixels_sent   = 0;
  int          frames_sent   = 0;
  bit          no_idle       = 1'b0;
  logic [7:0]  cur_thr       = ThresholdRst;

  threshold_run_length_encoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .coded_length_o (coded_length_o),
    .last_of_run_o  (last_of_run_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  threshold_run_length_encoder_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .pixel_i        (pixel_i),
    .frame_end_i    (frame_end_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .data_byte_i    (data_byte_o),
    .coded_length_i (coded_length_o),
    .last_of_run_i  (last_of_run_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .failures_o     (failures),
    .pending_o      (pending),
    .checked_o      (checked),
    .overflows_o    (overflows)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 6);
  end

  task automatic send_pixel(input logic [PixW-1:0] pix, input logic fe);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_i     <= pix;
    frame_end_i <= fe;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    if (fe) frames_sent++;
  endtask

  // Hold the sender off until every coded result has been seen.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_THRESHOLD) cur_thr = val[PixW-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PixW-1:0] pick_pixel(input bit white);
    if ($urandom_range(9) < 2) begin
      // land right on the threshold boundary
      if (white && cur_thr != 8'hFF) return cur_thr + 1'b1;
      if (!white) return cur_thr;
    end
    if (white && cur_thr != 8'hFF) return PixW'($urandom_range(255, int'(cur_thr) + 1));
    if (!white) return PixW'($urandom_range(int'(cur_thr), 0));
    return PixW'($urandom_range(255, 0));
  endfunction

  initial begin
    int              len;
    int              phase_px;
    bit              white;
    logic [PixW-1:0] thr;
    logic [LenW-1:0] lim;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: boundary pixels, single-pixel frames of each color.
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd0,   1'b1);
    send_pixel(8'd0,   1'b1);
    send_pixel(8'd200, 1'b1);
    drain();

    // Zero byte limit trips on the first pixel; then a halted frame end.
    write_reg(CFG_THRESHOLD, 16'hA5FF);
    write_reg(CFG_BYTE_LIMIT, 16'd0);
    send_pixel(8'd77,  1'b0);
    send_pixel(8'd10,  1'b0);
    send_pixel(8'd255, 1'b1);
    drain();

    // Overflow on the last pixel of a frame.
    write_reg(CFG_THRESHOLD, 16'h0000);
    write_reg(CFG_BYTE_LIMIT, 16'd4);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd5, 1'b1);
    drain();

    // Lower the limit mid-frame so the next pixel trips without sending bytes.
    write_reg(CFG_THRESHOLD, 16'd100);
    write_reg(CFG_BYTE_LIMIT, 16'd1024);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd50,  1'b0);
    send_pixel(8'd60,  1'b0);
    drain();
    write_reg(CFG_BYTE_LIMIT, 16'd2);
    send_pixel(8'd70, 1'b0);
    send_pixel(8'd1,  1'b1);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      thr = PixW'($urandom);
      lim = LenW'($urandom);
      case (p)
        0: lim = 16'd65534;
        1: begin
          thr = 8'd0;
          lim = 16'd1;
        end
        2: begin
          thr = 8'd255;
          lim = 16'd65535;
        end
        3: lim = LenW'($urandom_range(30, 2));
        4: lim = LenW'($urandom_range(65534, 1));
        5: lim = LenW'($urandom_range(60, 6));
        default: begin
        end
      endcase
      write_reg(CFG_THRESHOLD, {8'($urandom), thr});
      write_reg(CFG_BYTE_LIMIT, lim);
      no_idle  = (p == 0);
      phase_px = 0;
      while (phase_px < PhasePixels) begin
        len   = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        white = 1'($urandom_range(1));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) < 3) white = !white;
          send_pixel(pick_pixel(white), k == len - 1);
          if (k == len / 2 && $urandom_range(9) == 0) drain();
        end
        phase_px += len;
      end
      drain();
    end
    no_idle = 1'b0;

    $display("Sent %0d pixels in %0d frames across threshold and byte limit extremes,",
             pixels_sent, frames_sent);
    $display("with zero and tiny limits, mid-frame limit changes and halted frames; %0d results, %0d aborts.",
             checked, overflows);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: threshold_run_length_encoder_top.f
src/trle_pkg.sv
src/trle_resq.sv
src/threshold_run_length_encoder_top.sv
tb/sv/threshold_run_length_encoder_checker.sv
tb/sv/threshold_run_length_encoder_top_test.sv
